@@ sv/bmp_pkg.sv @@
package bmp_pkg;

  localparam int unsigned CNT_W = 16;
  localparam int unsigned OP_W  = 30;

  localparam logic [OP_W-1:0] PRIME_MOD = OP_W'(1000000007);
  localparam logic [OP_W-1:0] INV_EXP   = OP_W'(1000000005);

  // largest n served
  localparam int unsigned MAX_N = 65535;

  // digit counter width, then radix-4 digits per multiplier operand
  localparam int unsigned DIG_W        = 4;
  localparam int unsigned LONG_DIGITS  = OP_W / 2;
  localparam int unsigned SHORT_DIGITS = CNT_W / 2;

  typedef struct packed {
    logic [CNT_W-1:0] total_count;
    logic [CNT_W-1:0] choose_count;
  } in_item_t;

  typedef struct packed {
    logic [OP_W-1:0] binomial_value;
    logic            invalid_request;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic short_op;  // multiplier b holds a CNT_W-bit value
  } mul_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

@@ sv/bmp_mod_mul.sv @@
module bmp_mod_mul (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bmp_pkg::mul_ctrl_t       ctrl_i,
  input  logic [bmp_pkg::OP_W-1:0] a_i,
  input  logic [bmp_pkg::OP_W-1:0] b_i,
  output bmp_pkg::mul_stat_t       stat_o,
  output logic [bmp_pkg::OP_W-1:0] prod_o
);

  localparam logic [bmp_pkg::OP_W:0] PrimeExt = {1'b0, bmp_pkg::PRIME_MOD};

  logic [bmp_pkg::OP_W-1:0]  a_q;
  logic [bmp_pkg::OP_W-1:0]  b_sr_q, b_sr_d;
  logic [bmp_pkg::OP_W-1:0]  acc_q, acc_d;
  logic [bmp_pkg::DIG_W-1:0] cnt_q, cnt_d;
  logic                      run_q, run_d;
  logic                      done_q, done_d;

  // acc <- (2*acc + bit*a) mod p, with acc and a already reduced
  function automatic logic [bmp_pkg::OP_W-1:0] dbl_add(
    input logic [bmp_pkg::OP_W-1:0] acc,
    input logic [bmp_pkg::OP_W-1:0] a,
    input logic                     b
  );
    logic [bmp_pkg::OP_W:0] t;
    t = {acc, 1'b0};
    if (t >= PrimeExt) begin
      t = t - PrimeExt;
    end
    if (b) begin
      t = t + {1'b0, a};
    end
    if (t >= PrimeExt) begin
      t = t - PrimeExt;
    end
    return t[bmp_pkg::OP_W-1:0];
  endfunction

  always_comb begin
    b_sr_d = b_sr_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (run_q) begin
      acc_d  = dbl_add(dbl_add(acc_q, a_q, b_sr_q[bmp_pkg::OP_W-1]), a_q,
                       b_sr_q[bmp_pkg::OP_W-2]);
      b_sr_d = {b_sr_q[bmp_pkg::OP_W-3:0], 2'b00};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == bmp_pkg::DIG_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end else if (ctrl_i.start) begin
      acc_d = '0;
      run_d = 1'b1;
      if (ctrl_i.short_op) begin
        b_sr_d = {b_i[bmp_pkg::CNT_W-1:0], (bmp_pkg::OP_W - bmp_pkg::CNT_W)'(0)};
        cnt_d  = bmp_pkg::DIG_W'(bmp_pkg::SHORT_DIGITS);
      end else begin
        b_sr_d = b_i;
        cnt_d  = bmp_pkg::DIG_W'(bmp_pkg::LONG_DIGITS);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    b_sr_q <= b_sr_d;
    if (!run_q && ctrl_i.start) begin
      a_q <= a_i;
    end
  end

  assign stat_o.busy = run_q;
  assign stat_o.done = done_q;
  assign prod_o      = acc_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |-> !run_q)
    else $error("multiplier started while busy");
  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(run_q) && !run_q)
    else $error("done without a finished run");
  a_acc_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> acc_q < bmp_pkg::PRIME_MOD)
    else $error("product not reduced");

endmodule

@@ sv/binomial_mod_prime_unit.sv @@
// Returns C(n,r) mod 1000000007 for n = total_count, r = choose_count, one result per
// request. r > n gives 0 with invalid_request set; r = 0 gives 1. Both of those skip the
// multiplier and go straight to the done state. Otherwise the block walks k = 1..n building
// n! on one radix-4 serial modular multiplier (2 bits of the multiplier per cycle),
// keeping r! and (n-r)!, then raises r!*(n-r)! to p-2 and multiplies by n!. The exponent
// walk is 29 squarings, 15 multiplies for the set bits of p-2 and none for its 15 clear
// bits. One request is worked at a time; the finished result sits in an output register,
// so a new request is taken while it waits.
module binomial_mod_prime_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bmp_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bmp_pkg::out_item_t  out_data_o
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_FACT    = 7'b0000010,
    S_DEN     = 7'b0000100,
    S_EXP_MUL = 7'b0001000,
    S_EXP_SQR = 7'b0010000,
    S_FINAL   = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_e;

  localparam logic [bmp_pkg::OP_W-1:0] One = bmp_pkg::OP_W'(1);
  localparam logic [4:0] LastBit = 5'(bmp_pkg::OP_W - 1);

  state_e state_q, state_d;

  logic [bmp_pkg::CNT_W-1:0] n_q, n_d, r_q, r_d, nr_q, nr_d, k_q, k_d;
  logic [bmp_pkg::OP_W-1:0]  fact_q, fact_d, fr_q, fr_d, fnr_q, fnr_d;
  logic [bmp_pkg::OP_W-1:0]  acc_q, acc_d, base_q, base_d;
  logic [4:0]                bit_q, bit_d;
  logic                      issued_q, issued_d;
  bmp_pkg::out_item_t        res_q, res_d, out_q;
  logic                      out_valid_q, out_valid_d;
  logic                      out_load;

  bmp_pkg::mul_ctrl_t        mul_ctrl;
  bmp_pkg::mul_stat_t        mul_stat;
  logic [bmp_pkg::OP_W-1:0]  mul_a, mul_b, mul_p;
  logic                      mul_state;
  logic                      in_xfer;
  logic                      bad_req;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign bad_req    = (in_data_i.choose_count > in_data_i.total_count) ||
                      (32'(in_data_i.total_count) > bmp_pkg::MAX_N);

  always_comb begin
    mul_a = fact_q;
    mul_b = acc_q;
    case (state_q)
      S_FACT: begin
        mul_a = fact_q;
        mul_b = {(bmp_pkg::OP_W - bmp_pkg::CNT_W)'(0), k_q};
      end
      S_DEN: begin
        mul_a = fr_q;
        mul_b = fnr_q;
      end
      S_EXP_MUL: begin
        mul_a = acc_q;
        mul_b = base_q;
      end
      S_EXP_SQR: begin
        mul_a = base_q;
        mul_b = base_q;
      end
      default: begin
        mul_a = fact_q;
        mul_b = acc_q;
      end
    endcase
  end

  assign mul_state = (state_q == S_FACT) || (state_q == S_DEN) ||
                     ((state_q == S_EXP_MUL) && bmp_pkg::INV_EXP[bit_q]) ||
                     (state_q == S_EXP_SQR) || (state_q == S_FINAL);
  assign mul_ctrl.start    = mul_state && !issued_q && !mul_stat.busy;
  assign mul_ctrl.short_op = (state_q == S_FACT);

  bmp_mod_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mul_ctrl),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .stat_o (mul_stat),
    .prod_o (mul_p)
  );

  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d  = state_q;
    n_d      = n_q;
    r_d      = r_q;
    nr_d     = nr_q;
    k_d      = k_q;
    fact_d   = fact_q;
    fr_d     = fr_q;
    fnr_d    = fnr_q;
    acc_d    = acc_q;
    base_d   = base_q;
    bit_d    = bit_q;
    res_d    = res_q;
    issued_d = issued_q;
    if (mul_ctrl.start) begin
      issued_d = 1'b1;
    end
    if (mul_stat.done) begin
      issued_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          n_d    = in_data_i.total_count;
          r_d    = in_data_i.choose_count;
          nr_d   = in_data_i.total_count - in_data_i.choose_count;
          k_d    = bmp_pkg::CNT_W'(1);
          fact_d = One;
          fr_d   = One;
          fnr_d  = One;
          if (bad_req) begin
            res_d   = '{binomial_value: '0, invalid_request: 1'b1};
            state_d = S_DONE;
          end else if (in_data_i.choose_count == '0) begin
            res_d   = '{binomial_value: One, invalid_request: 1'b0};
            state_d = S_DONE;
          end else begin
            state_d = S_FACT;
          end
        end
      end
      S_FACT: begin
        if (mul_stat.done) begin
          fact_d = mul_p;
          if (k_q == r_q) begin
            fr_d = mul_p;
          end
          if (k_q == nr_q) begin
            fnr_d = mul_p;
          end
          if (k_q == n_q) begin
            state_d = S_DEN;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      S_DEN: begin
        if (mul_stat.done) begin
          base_d  = mul_p;
          acc_d   = One;
          bit_d   = '0;
          state_d = S_EXP_MUL;
        end
      end
      S_EXP_MUL: begin
        // zero exponent bit: no multiply, go straight on
        if (!bmp_pkg::INV_EXP[bit_q] || mul_stat.done) begin
          if (bmp_pkg::INV_EXP[bit_q]) begin
            acc_d = mul_p;
          end
          state_d = (bit_q == LastBit) ? S_FINAL : S_EXP_SQR;
        end
      end
      S_EXP_SQR: begin
        if (mul_stat.done) begin
          base_d  = mul_p;
          bit_d   = bit_q + 1'b1;
          state_d = S_EXP_MUL;
        end
      end
      S_FINAL: begin
        if (mul_stat.done) begin
          res_d   = '{binomial_value: mul_p, invalid_request: 1'b0};
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    r_q    <= r_d;
    nr_q   <= nr_d;
    k_q    <= k_d;
    fact_q <= fact_d;
    fr_q   <= fr_d;
    fnr_q  <= fnr_d;
    acc_q  <= acc_d;
    base_q <= base_d;
    bit_q  <= bit_d;
    res_q  <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_done_was_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_stat.done |-> issued_q)
    else $error("multiplier result with no operation in flight");
  a_k_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FACT) |-> (k_q != '0) && (k_q <= n_q))
    else $error("factorial index out of range");
  a_bit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXP_MUL || state_q == S_EXP_SQR) |-> bit_q <= LastBit)
    else $error("exponent bit index out of range");
  a_idle_no_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> !issued_q && !mul_stat.busy)
    else $error("multiplier active outside a compute state");

endmodule

@@ test/binomial_checker.sv @@
module binomial_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  bmp_pkg::in_item_t   in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  bmp_pkg::out_item_t  out_data_i,
  output int                  mismatch_count_o,
  output int                  pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned PRIME = longint'(bmp_pkg::PRIME_MOD);

  bmp_pkg::out_item_t binom_due_q[$];
  bmp_pkg::out_item_t want;
  int                 fails = 0;
  int                 due   = 0;

  assign mismatch_count_o = fails;
  assign pending_count_o  = due;

  function automatic longint unsigned mod_mul(longint unsigned a, longint unsigned b);
    return (a * b) % PRIME;
  endfunction

  function automatic longint unsigned mod_pow(longint unsigned base, longint unsigned expo);
    longint unsigned acc;
    acc  = 1;
    base = base % PRIME;
    while (expo != 0) begin
      if (expo[0]) acc = mod_mul(acc, base);
      base = mod_mul(base, base);
      expo = expo >> 1;
    end
    return acc;
  endfunction

  function automatic bmp_pkg::out_item_t binomial_of(bmp_pkg::in_item_t req);
    longint unsigned    n, r, k, fact, fact_r, fact_nr, v;
    bmp_pkg::out_item_t res;
    n   = req.total_count;
    r   = req.choose_count;
    res = '0;
    if (r > n || n > bmp_pkg::MAX_N) begin
      res.invalid_request = 1'b1;
      return res;
    end
    if (r == 0) begin
      res.binomial_value = bmp_pkg::OP_W'(1);
      return res;
    end
    fact    = 1;
    fact_r  = 1;
    fact_nr = 1;
    for (k = 1; k <= n; k++) begin
      fact = mod_mul(fact, k);
      if (k == r) fact_r = fact;
      if (k == n - r) fact_nr = fact;
    end
    // Fermat inverse: x^(p-2)
    v = mod_mul(fact, mod_pow(fact_r, PRIME - 2));
    v = mod_mul(v, mod_pow(fact_nr, PRIME - 2));
    res.binomial_value = v[bmp_pkg::OP_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      binom_due_q.delete();
      due = 0;
    end else begin
      // pop before push: a result never belongs to a request taken at the same edge
      if (out_valid_i && out_ready_i) begin
        if (binom_due_q.size() == 0) begin
          if (fails < 10)
            $display("unexpected result: value %0d invalid %0b",
                     out_data_i.binomial_value, out_data_i.invalid_request);
          fails++;
        end else begin
          want = binom_due_q.pop_front();
          if (out_data_i.binomial_value !== want.binomial_value ||
              out_data_i.invalid_request !== want.invalid_request) begin
            if (fails < 10)
              $display("result mismatch: expected value %0d invalid %0b, %s",
                       want.binomial_value, want.invalid_request,
                       $sformatf("got value %0d invalid %0b",
                                 out_data_i.binomial_value,
                                 out_data_i.invalid_request));
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) binom_due_q = {binom_due_q, binomial_of(in_data_i)};
      due = binom_due_q.size();
    end
  end

endmodule

@@ test/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT       = 8_000_000;
  localparam int HOLD_OFF_CYCLES = 20_000;
  localparam int RANDOM_ITEMS    = 81;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  bmp_pkg::in_item_t  in_data   = '0;
  logic               in_ready;
  logic               out_valid;
  logic               out_ready = 1'b0;
  bmp_pkg::out_item_t out_data;
  logic               hold_off  = 1'b0;

  int sent_count  = 0;
  int cycle_count = 0;
  int mismatch_count;
  int pending_count;

  binomial_mod_prime_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  binomial_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 96) return $urandom_range(4, 40);
    return $urandom_range(100, 2000);
  endfunction

  task automatic offer_request(input int unsigned n, input int unsigned r);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data  <= '{total_count: bmp_pkg::CNT_W'(n), choose_count: bmp_pkg::CNT_W'(r)};
    do @(posedge clk); while (!in_ready);
    sent_count++;
    gap = idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    int unsigned pick, n, r;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer_request(0, 0);
    offer_request(1, 0);
    offer_request(1, 1);
    offer_request(0, 1);
    offer_request(2, 2);
    offer_request(3, 1);
    offer_request(5, 2);
    offer_request(10, 5);
    offer_request(13, 7);
    offer_request(20, 10);
    offer_request(100, 1);
    offer_request(100, 99);
    offer_request(300, 150);
    offer_request(65535, 0);
    offer_request(0, 65535);
    offer_request(65534, 65535);
    offer_request(32768, 40000);
    offer_request('h2aaa, 'h5555);
    // the one full-size walk
    offer_request(65535, 21845);

    repeat (RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        n = $urandom_range(0, 40);
        r = $urandom_range(0, n);
      end else if (pick < 65) begin
        n = $urandom_range(41, 400);
        r = $urandom_range(0, n);
      end else if (pick < 80) begin
        // choose exceeds total, full field range
        n = $urandom_range(0, 65534);
        r = $urandom_range(n + 1, 65535);
      end else if (pick < 90) begin
        n = $urandom_range(0, 65535);
        r = 0;
      end else begin
        n = $urandom_range(1, 40);
        r = n - $urandom_range(0, 1);
      end
      offer_request(n, r);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    wait (pending_count == 0);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0)
      $display("PASS binomial_mod_prime_unit");
    else
      $display("FAIL binomial_mod_prime_unit");
    $finish;
  end

  // long receiver hold-off while requests keep coming, so the input stalls
  initial begin : pressure
    wait (sent_count >= 40);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : receiver
    int unsigned left;
    logic        level;
    left  = 0;
    level = 1'b1;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (left == 0) begin
        level = ($urandom_range(0, 3) != 0);
        left  = level ? $urandom_range(1, 60) : idle_len() + 1;
      end
      left--;
      out_ready <= hold_off ? 1'b0 : level;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("FAIL binomial_mod_prime_unit");
      $finish;
    end
  end

endmodule
